/* hw/rtl/voxel_ray_traversal_assert.svh */
// Assertion macros used by the voxel ray traversal controller.
`ifndef VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define VRT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voxel ray traversal assertion failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define VRT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("voxel ray traversal assertion failed");

`endif

/* hw/rtl/vrt_pkg.sv */
// Shared types, constants and command structures of the voxel ray traversal block.
package vrt_pkg;

  localparam int unsigned MAX_RUN_DEF    = 64;
  localparam int unsigned INDEX_BITS_DEF = 24;

  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned VOX_W     = 24;
  localparam int unsigned EXT_W     = 32;
  localparam int unsigned DIFF_W    = 33;
  localparam int unsigned MAG_W     = 33;
  localparam int unsigned OPND_W    = 34;
  localparam int unsigned PROD_W    = 68;
  localparam int unsigned SUM_W     = 66;
  localparam int unsigned LEN_W     = 33;
  localparam int unsigned OFF_W     = 26;
  localparam int unsigned PT_W      = 34;
  localparam int unsigned SC_W      = 42;
  localparam int unsigned SCI_W     = 26;
  localparam int unsigned R_W       = 43;
  localparam int unsigned T_W       = 40;
  localparam int unsigned TOT_W     = 28;
  localparam int unsigned DIV_NW    = 58;
  localparam int unsigned DIV_DW    = 43;

  localparam logic [T_W-1:0]    T_MAX      = '1;
  localparam logic [DIV_NW-1:0] TD_NUM     = DIV_NW'(1) << 48;
  localparam logic [1:0]        DIR_NONE   = 2'b00;
  localparam logic [1:0]        DIR_POS    = 2'b01;
  localparam logic [1:0]        DIR_NEG    = 2'b11;
  localparam logic [1:0]        AX_FIRST   = 2'd0;
  localparam logic [1:0]        AX_LAST    = 2'd2;

  localparam logic [CFG_W-1:0] VOXEL_SCALE_RST = 24'd1310720;
  localparam logic [CFG_W-1:0] TRUNC_DIST_RST  = 24'd6554;
  localparam logic [CFG_W-1:0] MAX_RAY_LEN_RST = 24'd327680;
  localparam logic             CARVING_ON_RST  = 1'b0;
  localparam logic             FROM_ORIGIN_RST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOXEL_SCALE,
    CFG_TRUNC_DIST,
    CFG_MAX_RAY_LEN,
    CFG_CARVING_ON,
    CFG_FROM_ORIGIN
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_K,
    ST_OFF_MUL,
    ST_OFF_DIV,
    ST_OFF_WAIT,
    ST_SC_MUL_S,
    ST_SC_MUL_E,
    ST_SC_STORE,
    ST_SC_AXIS,
    ST_TN_GO,
    ST_TN_WAIT,
    ST_TD_GO,
    ST_TD_WAIT,
    ST_RUN_GO,
    ST_RUN
  } state_t;

  typedef enum logic [1:0] {MUL_SQ, MUL_OFF, MUL_S, MUL_E} mul_sel_t;
  typedef enum logic [1:0] {DIV_OFF, DIV_TN, DIV_TD} div_sel_t;

  typedef struct packed {
    logic       load;
    logic       sq_acc;
    logic       sqrt_start;
    logic       len_load;
    logic       k_load;
    mul_sel_t   mul_sel;
    logic       div_start;
    div_sel_t   div_sel;
    logic       off_store;
    logic       ss_store;
    logic       es_store;
    logic       axis_setup;
    logic       tn_store;
    logic       td_store;
    logic       run_start;
    logic       emit;
    logic [1:0] ax;
  } cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic sqrt_done;
    logic div_busy;
    logic div_done;
    logic len_zero;
    logic r_zero;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

/* hw/rtl/vrt_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module vrt_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [vrt_pkg::DIV_NW-1:0]      num,
  input  logic [vrt_pkg::DIV_DW-1:0]      den,
  output logic                            busy,
  output logic                            done,
  output logic [vrt_pkg::DIV_NW-1:0]      quo
);

  localparam int unsigned NW = vrt_pkg::DIV_NW;
  localparam int unsigned DW = vrt_pkg::DIV_DW;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [NW-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, q_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;

endmodule

/* hw/rtl/vrt_sqrt.sv */
// Digit-by-digit integer square root that resolves one root bit per cycle.
module vrt_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [vrt_pkg::SUM_W-1:0]      rad,
  output logic                           busy,
  output logic                           done,
  output logic [vrt_pkg::LEN_W-1:0]      root
);

  localparam int unsigned RW = vrt_pkg::SUM_W;
  localparam int unsigned QW = vrt_pkg::LEN_W;
  localparam int unsigned MW = QW + 2;
  localparam int unsigned CW = $clog2(QW + 1);

  logic [RW-1:0]   rad_r;
  logic [MW-1:0]   rem_r;
  logic [QW-1:0]   root_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [MW+1:0]   rem2;
  logic [MW+1:0]   trial;
  logic [MW+1:0]   diff;
  logic            ge;

  assign rem2  = {rem_r, rad_r[RW-1:RW-2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign diff  = rem2 - trial;
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RW-3:0], 2'b00};
      rem_r  <= ge ? diff[MW-1:0] : rem2[MW-1:0];
      root_r <= {root_r[QW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

/* hw/rtl/vrt_ctrl.sv */
// Controller state machine that sequences ray setup and the voxel walk.
`include "voxel_ray_traversal_assert.svh"

module vrt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  vrt_pkg::sts_t sts,
  output vrt_pkg::cmd_t cmd
);

  vrt_pkg::state_t state_r;
  vrt_pkg::state_t state_nxt;
  logic [1:0]      ax_r;
  logic [1:0]      ax_nxt;
  logic            ax_last;

  assign ax_last = (ax_r == vrt_pkg::AX_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vrt_pkg::ST_IDLE;
      ax_r    <= vrt_pkg::AX_FIRST;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ax_nxt      = ax_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.ax      = ax_r;
    cmd.mul_sel = vrt_pkg::MUL_SQ;
    cmd.div_sel = vrt_pkg::DIV_OFF;
    case (state_r)
      vrt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          ax_nxt    = vrt_pkg::AX_FIRST;
          state_nxt = vrt_pkg::ST_SQ_MUL;
        end
      end
      vrt_pkg::ST_SQ_MUL: begin
        cmd.mul_sel = vrt_pkg::MUL_SQ;
        state_nxt   = vrt_pkg::ST_SQ_ACC;
      end
      vrt_pkg::ST_SQ_ACC: begin
        cmd.sq_acc = 1'b1;
        if (ax_last) begin
          ax_nxt    = vrt_pkg::AX_FIRST;
          state_nxt = vrt_pkg::ST_SQRT_GO;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = vrt_pkg::ST_SQ_MUL;
        end
      end
      vrt_pkg::ST_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = vrt_pkg::ST_SQRT_WAIT;
      end
      vrt_pkg::ST_SQRT_WAIT: begin
        if (sts.sqrt_done) begin
          cmd.len_load = 1'b1;
          state_nxt    = vrt_pkg::ST_K;
        end
      end
      vrt_pkg::ST_K: begin
        cmd.k_load = 1'b1;
        ax_nxt     = vrt_pkg::AX_FIRST;
        state_nxt  = vrt_pkg::ST_OFF_MUL;
      end
      vrt_pkg::ST_OFF_MUL: begin
        cmd.mul_sel = vrt_pkg::MUL_OFF;
        state_nxt   = vrt_pkg::ST_OFF_DIV;
      end
      vrt_pkg::ST_OFF_DIV: begin
        cmd.div_sel = vrt_pkg::DIV_OFF;
        if (sts.len_zero) begin
          cmd.off_store = 1'b1;
          if (ax_last) begin
            ax_nxt    = vrt_pkg::AX_FIRST;
            state_nxt = vrt_pkg::ST_SC_MUL_S;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = vrt_pkg::ST_OFF_MUL;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = vrt_pkg::ST_OFF_WAIT;
        end
      end
      vrt_pkg::ST_OFF_WAIT: begin
        if (sts.div_done) begin
          cmd.off_store = 1'b1;
          if (ax_last) begin
            ax_nxt    = vrt_pkg::AX_FIRST;
            state_nxt = vrt_pkg::ST_SC_MUL_S;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = vrt_pkg::ST_OFF_MUL;
          end
        end
      end
      vrt_pkg::ST_SC_MUL_S: begin
        cmd.mul_sel = vrt_pkg::MUL_S;
        state_nxt   = vrt_pkg::ST_SC_MUL_E;
      end
      vrt_pkg::ST_SC_MUL_E: begin
        cmd.mul_sel  = vrt_pkg::MUL_E;
        cmd.ss_store = 1'b1;
        state_nxt    = vrt_pkg::ST_SC_STORE;
      end
      vrt_pkg::ST_SC_STORE: begin
        cmd.es_store = 1'b1;
        state_nxt    = vrt_pkg::ST_SC_AXIS;
      end
      vrt_pkg::ST_SC_AXIS: begin
        cmd.axis_setup = 1'b1;
        if (!sts.r_zero) begin
          state_nxt = vrt_pkg::ST_TN_GO;
        end else if (ax_last) begin
          state_nxt = vrt_pkg::ST_RUN_GO;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = vrt_pkg::ST_SC_MUL_S;
        end
      end
      vrt_pkg::ST_TN_GO: begin
        cmd.div_sel   = vrt_pkg::DIV_TN;
        cmd.div_start = 1'b1;
        state_nxt     = vrt_pkg::ST_TN_WAIT;
      end
      vrt_pkg::ST_TN_WAIT: begin
        if (sts.div_done) begin
          cmd.tn_store = 1'b1;
          state_nxt    = vrt_pkg::ST_TD_GO;
        end
      end
      vrt_pkg::ST_TD_GO: begin
        cmd.div_sel   = vrt_pkg::DIV_TD;
        cmd.div_start = 1'b1;
        state_nxt     = vrt_pkg::ST_TD_WAIT;
      end
      vrt_pkg::ST_TD_WAIT: begin
        if (sts.div_done) begin
          cmd.td_store = 1'b1;
          if (ax_last) begin
            state_nxt = vrt_pkg::ST_RUN_GO;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = vrt_pkg::ST_SC_MUL_S;
          end
        end
      end
      vrt_pkg::ST_RUN_GO: begin
        cmd.run_start = 1'b1;
        state_nxt     = vrt_pkg::ST_RUN;
      end
      vrt_pkg::ST_RUN: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_nxt = vrt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = vrt_pkg::ST_IDLE;
      end
    endcase
  end

  `VRT_ASSERT_IMP(a_div_idle, cmd.div_start, !sts.div_busy)
  `VRT_ASSERT_IMP(a_sqrt_idle, cmd.sqrt_start, !sts.sqrt_busy)
  `VRT_ASSERT_IMP(a_emit_room, cmd.emit, sts.out_free)
  `VRT_ASSERT_NXT(a_tn_runs, state_r == vrt_pkg::ST_TN_GO, sts.div_busy && !in_ready)

endmodule

/* hw/rtl/vrt_dp.sv */
// Datapath holding configuration, ray setup arithmetic, walk state and the result register.
module vrt_dp #(
  parameter int unsigned MAX_RUN    = vrt_pkg::MAX_RUN_DEF,
  parameter int unsigned INDEX_BITS = vrt_pkg::INDEX_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [vrt_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [vrt_pkg::CFG_W-1:0]              cfg_wdata,
  input  logic signed [vrt_pkg::COORD_W-1:0]     in_origin_x,
  input  logic signed [vrt_pkg::COORD_W-1:0]     in_origin_y,
  input  logic signed [vrt_pkg::COORD_W-1:0]     in_origin_z,
  input  logic signed [vrt_pkg::COORD_W-1:0]     in_hit_x,
  input  logic signed [vrt_pkg::COORD_W-1:0]     in_hit_y,
  input  logic signed [vrt_pkg::COORD_W-1:0]     in_hit_z,
  input  logic                                   in_clearing,
  input  vrt_pkg::cmd_t                          cmd,
  output vrt_pkg::sts_t                          sts,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [vrt_pkg::VOX_W-1:0]       out_voxel_x,
  output logic signed [vrt_pkg::VOX_W-1:0]       out_voxel_y,
  output logic signed [vrt_pkg::VOX_W-1:0]       out_voxel_z,
  output logic                                   out_last,
  output logic                                   out_truncated
);

  localparam int unsigned CNT_W = $clog2(MAX_RUN + 1);
  localparam int unsigned CW    = vrt_pkg::CFG_W;
  localparam int unsigned TW    = vrt_pkg::T_W;

  logic [CW-1:0] vs_r;
  logic [CW-1:0] trunc_dist_r;
  logic [CW-1:0] mrl_r;
  logic          carve_r;
  logic          fwd_r;

  logic signed [vrt_pkg::COORD_W-1:0] o_r [3];
  logic signed [vrt_pkg::COORD_W-1:0] h_r [3];
  logic                               clr_r;
  logic                               dneg_r [3];
  logic [vrt_pkg::MAG_W-1:0]          dm_r [3];
  logic [vrt_pkg::SUM_W-1:0]          sum_r;
  logic [vrt_pkg::LEN_W-1:0]          len_r;
  logic [CW-1:0]                      k_r;
  logic signed [vrt_pkg::PROD_W-1:0]  prod_r;
  logic signed [vrt_pkg::PT_W-1:0]    e_r [3];
  logic signed [vrt_pkg::PT_W-1:0]    s_r [3];
  logic signed [vrt_pkg::SC_W-1:0]    ss_r;
  logic signed [vrt_pkg::SC_W-1:0]    es_r;
  logic [vrt_pkg::TOT_W-1:0]          total_r;
  logic [INDEX_BITS-1:0]              cell_r [3];
  logic [TW-1:0]                      tn_r [3];
  logic [TW-1:0]                      tdl_r [3];
  logic [1:0]                         dir_r [3];
  logic [CNT_W-1:0]                   cnt_r;
  logic [CNT_W-1:0]                   emit_r;
  logic                               trunc_r;
  logic                               out_valid_r;
  logic signed [vrt_pkg::VOX_W-1:0]   vox_r [3];
  logic                               last_r;
  logic                               otrunc_r;

  logic signed [vrt_pkg::DIFF_W-1:0]  d_in [3];
  logic signed [vrt_pkg::OPND_W-1:0]  mul_a;
  logic signed [vrt_pkg::OPND_W-1:0]  mul_b;
  logic [vrt_pkg::DIV_NW-1:0]         div_num;
  logic [vrt_pkg::DIV_DW-1:0]         div_den;
  logic [vrt_pkg::DIV_NW-1:0]         div_quo;
  logic                               div_busy;
  logic                               div_done;
  logic [vrt_pkg::LEN_W-1:0]          sqrt_root;
  logic                               sqrt_busy;
  logic                               sqrt_done;
  logic [vrt_pkg::LEN_W-1:0]          lsub;
  logic [CW-1:0]                      k_nxt;
  logic [CW-1:0]                      q_off;
  logic signed [vrt_pkg::OFF_W-1:0]   off;
  logic signed [vrt_pkg::PT_W-1:0]    o_ext;
  logic signed [vrt_pkg::PT_W-1:0]    h_ext;
  logic signed [vrt_pkg::PT_W-1:0]    off_ext;
  logic signed [vrt_pkg::PT_W-1:0]    e_nxt;
  logic signed [vrt_pkg::PT_W-1:0]    s_nxt;
  logic signed [vrt_pkg::SC_W-1:0]    ssw;
  logic signed [vrt_pkg::SC_W-1:0]    esw;
  logic signed [vrt_pkg::SCI_W-1:0]   is_idx;
  logic signed [vrt_pkg::SCI_W-1:0]   ie_idx;
  logic signed [vrt_pkg::SCI_W:0]     idx_diff;
  logic [vrt_pkg::SCI_W:0]            idx_mag;
  logic signed [vrt_pkg::R_W-1:0]     rs;
  logic [vrt_pkg::R_W-1:0]            r_mag;
  logic                               r_zero;
  logic                               r_pos;
  logic [16:0]                        bnd_dist;
  logic [TW-1:0]                      q_sat;
  logic                               mv [3];
  logic                               sel [3];
  logic [TW:0]                        tn_sum [3];
  logic signed [vrt_pkg::EXT_W-1:0]   vox_ext [3];
  logic                               emit_last;

  vrt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  vrt_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .rad   (sum_r),
    .busy  (sqrt_busy),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign d_in[0] = vrt_pkg::DIFF_W'(in_hit_x) - vrt_pkg::DIFF_W'(in_origin_x);
  assign d_in[1] = vrt_pkg::DIFF_W'(in_hit_y) - vrt_pkg::DIFF_W'(in_origin_y);
  assign d_in[2] = vrt_pkg::DIFF_W'(in_hit_z) - vrt_pkg::DIFF_W'(in_origin_z);

  always_comb begin
    case (cmd.mul_sel)
      vrt_pkg::MUL_SQ: begin
        mul_a = signed'({1'b0, dm_r[cmd.ax]});
        mul_b = signed'({1'b0, dm_r[cmd.ax]});
      end
      vrt_pkg::MUL_OFF: begin
        mul_a = signed'({1'b0, dm_r[cmd.ax]});
        mul_b = signed'({10'b0, k_r});
      end
      vrt_pkg::MUL_S: begin
        mul_a = s_r[cmd.ax];
        mul_b = signed'({10'b0, vs_r});
      end
      vrt_pkg::MUL_E: begin
        mul_a = e_r[cmd.ax];
        mul_b = signed'({10'b0, vs_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign lsub  = (len_r > vrt_pkg::LEN_W'(trunc_dist_r)) ?
                 len_r - vrt_pkg::LEN_W'(trunc_dist_r) : '0;
  assign k_nxt = !clr_r ? trunc_dist_r :
                 (lsub > vrt_pkg::LEN_W'(mrl_r)) ? mrl_r : lsub[CW-1:0];

  assign ssw      = fwd_r ? ss_r : es_r;
  assign esw      = fwd_r ? es_r : ss_r;
  assign is_idx   = ssw[vrt_pkg::SC_W-1:16];
  assign ie_idx   = esw[vrt_pkg::SC_W-1:16];
  assign idx_diff = (vrt_pkg::SCI_W + 1)'(ie_idx) - (vrt_pkg::SCI_W + 1)'(is_idx);
  assign idx_mag  = idx_diff[vrt_pkg::SCI_W] ? unsigned'(-idx_diff) : unsigned'(idx_diff);
  assign rs       = vrt_pkg::R_W'(esw) - vrt_pkg::R_W'(ssw);
  assign r_mag    = rs[vrt_pkg::R_W-1] ? unsigned'(-rs) : unsigned'(rs);
  assign r_zero   = (rs == '0);
  assign r_pos    = !rs[vrt_pkg::R_W-1] && !r_zero;
  assign bnd_dist = r_pos ? 17'h10000 - {1'b0, ssw[15:0]} : {1'b0, ssw[15:0]};

  always_comb begin
    case (cmd.div_sel)
      vrt_pkg::DIV_OFF: begin
        div_num = vrt_pkg::DIV_NW'(prod_r[56:0]) + vrt_pkg::DIV_NW'(len_r[vrt_pkg::LEN_W-1:1]);
        div_den = vrt_pkg::DIV_DW'(len_r);
      end
      vrt_pkg::DIV_TN: begin
        div_num = vrt_pkg::DIV_NW'({bnd_dist, 32'b0});
        div_den = r_mag;
      end
      vrt_pkg::DIV_TD: begin
        div_num = vrt_pkg::TD_NUM;
        div_den = r_mag;
      end
      default: begin
        div_num = '0;
        div_den = r_mag;
      end
    endcase
  end

  assign q_off   = (len_r == '0) ? '0 : div_quo[CW-1:0];
  assign off     = dneg_r[cmd.ax] ? -signed'({2'b00, q_off}) : signed'({2'b00, q_off});
  assign o_ext   = vrt_pkg::PT_W'(o_r[cmd.ax]);
  assign h_ext   = vrt_pkg::PT_W'(h_r[cmd.ax]);
  assign off_ext = vrt_pkg::PT_W'(off);
  assign e_nxt   = clr_r ? o_ext + off_ext : h_ext + off_ext;
  assign s_nxt   = carve_r ? o_ext : (clr_r ? e_nxt : h_ext - off_ext);

  assign q_sat = (|div_quo[vrt_pkg::DIV_NW-1:TW]) ? vrt_pkg::T_MAX : div_quo[TW-1:0];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    assign mv[i]      = (dir_r[i] != vrt_pkg::DIR_NONE);
    assign tn_sum[i]  = {1'b0, tn_r[i]} + {1'b0, tdl_r[i]};
    assign vox_ext[i] = vrt_pkg::EXT_W'(signed'(cell_r[i]));
  end

  assign sel[0] = mv[0] && !(mv[1] && tn_r[1] < tn_r[0]) && !(mv[2] && tn_r[2] < tn_r[0]);
  assign sel[1] = mv[1] && (!mv[0] || tn_r[1] < tn_r[0]) && !(mv[2] && tn_r[2] < tn_r[1]);
  assign sel[2] = mv[2] && (!mv[0] || tn_r[2] < tn_r[0]) && (!mv[1] || tn_r[2] < tn_r[1]);

  assign emit_last = ((emit_r + CNT_W'(1)) == cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r         <= vrt_pkg::VOXEL_SCALE_RST;
      trunc_dist_r <= vrt_pkg::TRUNC_DIST_RST;
      mrl_r        <= vrt_pkg::MAX_RAY_LEN_RST;
      carve_r      <= vrt_pkg::CARVING_ON_RST;
      fwd_r        <= vrt_pkg::FROM_ORIGIN_RST;
    end else if (cfg_we) begin
      case (vrt_pkg::cfg_idx_t'(cfg_index))
        vrt_pkg::CFG_VOXEL_SCALE: vs_r         <= cfg_wdata;
        vrt_pkg::CFG_TRUNC_DIST:  trunc_dist_r <= cfg_wdata;
        vrt_pkg::CFG_MAX_RAY_LEN: mrl_r        <= cfg_wdata;
        vrt_pkg::CFG_CARVING_ON:  carve_r      <= cfg_wdata[0];
        vrt_pkg::CFG_FROM_ORIGIN: fwd_r        <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      emit_r      <= '0;
      cnt_r       <= '0;
      trunc_r     <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.run_start) begin
        emit_r  <= '0;
        trunc_r <= (total_r >= vrt_pkg::TOT_W'(MAX_RUN));
        cnt_r   <= (total_r >= vrt_pkg::TOT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) :
                   CNT_W'(total_r) + CNT_W'(1);
      end else if (cmd.emit) begin
        emit_r <= emit_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.load) begin
      o_r[0] <= in_origin_x;
      o_r[1] <= in_origin_y;
      o_r[2] <= in_origin_z;
      h_r[0] <= in_hit_x;
      h_r[1] <= in_hit_y;
      h_r[2] <= in_hit_z;
      clr_r  <= in_clearing;
      for (int i = 0; i < 3; i++) begin
        dneg_r[i] <= d_in[i][vrt_pkg::DIFF_W-1];
        dm_r[i]   <= d_in[i][vrt_pkg::DIFF_W-1] ? unsigned'(-d_in[i]) : unsigned'(d_in[i]);
      end
      sum_r   <= '0;
      total_r <= '0;
    end
    if (cmd.sq_acc) begin
      sum_r <= sum_r + prod_r[vrt_pkg::SUM_W-1:0];
    end
    if (cmd.len_load) begin
      len_r <= sqrt_root;
    end
    if (cmd.k_load) begin
      k_r <= k_nxt;
    end
    if (cmd.off_store) begin
      e_r[cmd.ax] <= e_nxt;
      s_r[cmd.ax] <= s_nxt;
    end
    if (cmd.ss_store) begin
      ss_r <= prod_r[57:16];
    end
    if (cmd.es_store) begin
      es_r <= prod_r[57:16];
    end
    if (cmd.axis_setup) begin
      total_r          <= total_r + vrt_pkg::TOT_W'(idx_mag);
      cell_r[cmd.ax]   <= INDEX_BITS'(is_idx);
      dir_r[cmd.ax]    <= r_zero ? vrt_pkg::DIR_NONE : (r_pos ? vrt_pkg::DIR_POS : vrt_pkg::DIR_NEG);
      tn_r[cmd.ax]     <= vrt_pkg::T_MAX;
      tdl_r[cmd.ax]    <= vrt_pkg::T_MAX;
    end
    if (cmd.tn_store) begin
      tn_r[cmd.ax] <= q_sat;
    end
    if (cmd.td_store) begin
      tdl_r[cmd.ax] <= q_sat;
    end
    if (cmd.emit) begin
      for (int i = 0; i < 3; i++) begin
        vox_r[i] <= vox_ext[i][vrt_pkg::VOX_W-1:0];
        if (sel[i]) begin
          cell_r[i] <= (dir_r[i] == vrt_pkg::DIR_POS) ? cell_r[i] + INDEX_BITS'(1) :
                       cell_r[i] - INDEX_BITS'(1);
          tn_r[i]   <= tn_sum[i][TW] ? vrt_pkg::T_MAX : tn_sum[i][TW-1:0];
        end
      end
      last_r   <= emit_last;
      otrunc_r <= trunc_r;
    end
  end

  assign sts.sqrt_busy = sqrt_busy;
  assign sts.sqrt_done = sqrt_done;
  assign sts.div_busy  = div_busy;
  assign sts.div_done  = div_done;
  assign sts.len_zero  = (len_r == '0);
  assign sts.r_zero    = r_zero;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.emit_last = emit_last;

  assign out_valid     = out_valid_r;
  assign out_voxel_x   = vox_r[0];
  assign out_voxel_y   = vox_r[1];
  assign out_voxel_z   = vox_r[2];
  assign out_last      = last_r;
  assign out_truncated = otrunc_r;

endmodule

/* hw/rtl/voxel_ray_traversal.sv */
// Top level of the voxel ray traversal block: controller and datapath.
//
//   word     direction  handshake            payload
//   in_      input      in_valid/in_ready    ray origin, hit point, clearing flag
//   out_     output     out_valid/out_ready  voxel index, last, truncated
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// A ray uses the length square root, up to nine divisions on the shared divider for offsets
// and boundary steps, then one voxel word per cycle while the output is not stalled.
// The shared restoring divider sets most of the setup time.
// Synchronous reset restores the register defaults and idles the sequencer; no clearing pass.
// A stalled output holds the walk; a new ray is taken while the final word still waits.
module voxel_ray_traversal #(
  parameter int unsigned MAX_RUN    = vrt_pkg::MAX_RUN_DEF,
  parameter int unsigned INDEX_BITS = vrt_pkg::INDEX_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [vrt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vrt_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [vrt_pkg::COORD_W-1:0]   in_origin_x,
  input  logic signed [vrt_pkg::COORD_W-1:0]   in_origin_y,
  input  logic signed [vrt_pkg::COORD_W-1:0]   in_origin_z,
  input  logic signed [vrt_pkg::COORD_W-1:0]   in_hit_x,
  input  logic signed [vrt_pkg::COORD_W-1:0]   in_hit_y,
  input  logic signed [vrt_pkg::COORD_W-1:0]   in_hit_z,
  input  logic                                 in_clearing,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [vrt_pkg::VOX_W-1:0]     out_voxel_x,
  output logic signed [vrt_pkg::VOX_W-1:0]     out_voxel_y,
  output logic signed [vrt_pkg::VOX_W-1:0]     out_voxel_z,
  output logic                                 out_last,
  output logic                                 out_truncated
);

  vrt_pkg::cmd_t cmd;
  vrt_pkg::sts_t sts;

  vrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vrt_dp #(
    .MAX_RUN    (MAX_RUN),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_origin_x   (in_origin_x),
    .in_origin_y   (in_origin_y),
    .in_origin_z   (in_origin_z),
    .in_hit_x      (in_hit_x),
    .in_hit_y      (in_hit_y),
    .in_hit_z      (in_hit_z),
    .in_clearing   (in_clearing),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_voxel_x   (out_voxel_x),
    .out_voxel_y   (out_voxel_y),
    .out_voxel_z   (out_voxel_z),
    .out_last      (out_last),
    .out_truncated (out_truncated)
  );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the voxel ray traversal block, with its own grid-walk predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_CAP = 64;
  localparam longint unsigned STEP_SAT = (64'd1 << 26) - 1;
  localparam logic [vrt_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_CYCLES = 1500;
  localparam int RANDOM_PER_SETTING = 35;

  typedef struct {
    logic signed [31:0] ox, oy, oz, hx, hy, hz;
    logic clr;
    logic typed;
    logic signed [23:0] vx, vy, vz;
  } ray_t;

  typedef struct {
    logic [23:0] x, y, z;
    logic last, trunc;
  } voxel_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [vrt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vrt_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [31:0] in_hit_x = '0, in_hit_y = '0, in_hit_z = '0;
  logic in_clearing = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] out_voxel_x, out_voxel_y, out_voxel_z;
  logic out_last, out_truncated;

  logic [23:0] scale_q = vrt_pkg::VOXEL_SCALE_RST;
  logic [23:0] trunc_q = vrt_pkg::TRUNC_DIST_RST;
  logic [23:0] maxlen_q = vrt_pkg::MAX_RAY_LEN_RST;
  logic carving_q = vrt_pkg::CARVING_ON_RST;
  logic forward_q = vrt_pkg::FROM_ORIGIN_RST;

  voxel_word_t voxels_due[$];
  int errors = 0;
  int rays_sent = 0;
  int burst_left = 0;
  int quiet_cycles = 0;

  voxel_ray_traversal dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint offset_along(longint dd, longint unsigned k, longint unsigned len);
    logic [127:0] q;
    if (len == 0) return 0;
    q = (128'(mag(dd)) * 128'(k) + 128'(len / 2)) / 128'(len);
    return dd < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  task automatic walk_ray(input ray_t r);
    longint o[3], h[3], d[3], s[3], e[3];
    longint ss, es, rs, tmp, off, cell_s, cell_e;
    logic [127:0] sumsq, c;
    longint unsigned len, l, rmag, frac, bnd_dist, total, steps, cnt;
    longint unsigned tn[3], td[3];
    logic [1:0] dir[3];
    logic [23:0] cur_cell[3];
    int best;
    voxel_word_t w;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    h[0] = r.hx; h[1] = r.hy; h[2] = r.hz;
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = h[i] - o[i];
      sumsq += 128'(mag(d[i])) * 128'(mag(d[i]));
    end
    len = 0;
    for (int b = 34; b >= 0; b--) begin
      c = 128'(len | (64'd1 << b));
      if (c * c <= sumsq) len = c[63:0];
    end
    if (r.clr) begin
      l = len > trunc_q ? len - trunc_q : 0;
      if (l > maxlen_q) l = maxlen_q;
      for (int i = 0; i < 3; i++) begin
        e[i] = o[i] + offset_along(d[i], l, len);
        s[i] = carving_q ? o[i] : e[i];
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        off = offset_along(d[i], trunc_q, len);
        e[i] = h[i] + off;
        s[i] = carving_q ? o[i] : h[i] - off;
      end
    end
    total = 0;
    for (int i = 0; i < 3; i++) begin
      ss = (s[i] * longint'(scale_q)) >>> 16;
      es = (e[i] * longint'(scale_q)) >>> 16;
      if (!forward_q) begin
        tmp = ss; ss = es; es = tmp;
      end
      cell_s = ss >>> 16;
      cell_e = es >>> 16;
      total += mag(cell_e - cell_s);
      cur_cell[i] = cell_s[23:0];
      rs = es - ss;
      rmag = mag(rs);
      frac = ss & 64'hFFFF;
      if (rmag == 0) begin
        dir[i] = vrt_pkg::DIR_NONE;
        tn[i] = vrt_pkg::T_MAX;
        td[i] = vrt_pkg::T_MAX;
      end else begin
        dir[i] = rs > 0 ? vrt_pkg::DIR_POS : vrt_pkg::DIR_NEG;
        bnd_dist = rs > 0 ? 64'h10000 - frac : frac;
        tn[i] = (bnd_dist << 32) / rmag;
        if (tn[i] > vrt_pkg::T_MAX) tn[i] = vrt_pkg::T_MAX;
        td[i] = (64'd1 << 48) / rmag;
        if (td[i] > vrt_pkg::T_MAX) td[i] = vrt_pkg::T_MAX;
      end
    end
    steps = total > STEP_SAT ? STEP_SAT : total;
    cnt = steps + 1 > RUN_CAP ? RUN_CAP : steps + 1;
    for (longint unsigned k = 0; k < cnt; k++) begin
      w.x = cur_cell[0]; w.y = cur_cell[1]; w.z = cur_cell[2];
      w.last = (k + 1 == cnt);
      w.trunc = (steps + 1 > RUN_CAP);
      voxels_due.push_back(w);
      best = 3;
      for (int i = 0; i < 3; i++)
        if (dir[i] != vrt_pkg::DIR_NONE && (best == 3 || tn[i] < tn[best])) best = i;
      if (best != 3) begin
        cur_cell[best] = dir[best] == vrt_pkg::DIR_POS ? cur_cell[best] + 24'd1 :
                         cur_cell[best] - 24'd1;
        tn[best] += td[best];
        if (tn[best] > vrt_pkg::T_MAX) tn[best] = vrt_pkg::T_MAX;
      end
    end
  endtask

  task automatic write_reg(input logic [vrt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vrt_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      vrt_pkg::CFG_VOXEL_SCALE: scale_q = val;
      vrt_pkg::CFG_TRUNC_DIST: trunc_q = val;
      vrt_pkg::CFG_MAX_RAY_LEN: maxlen_q = val;
      vrt_pkg::CFG_CARVING_ON: carving_q = val[0];
      vrt_pkg::CFG_FROM_ORIGIN: forward_q = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (voxels_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_ray(input ray_t r);
    voxel_word_t w;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    in_origin_x = r.ox; in_origin_y = r.oy; in_origin_z = r.oz;
    in_hit_x = r.hx; in_hit_y = r.hy; in_hit_z = r.hz;
    in_clearing = r.clr;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (r.typed) begin
      w.x = r.vx; w.y = r.vy; w.z = r.vz;
      w.last = 1'b1;
      w.trunc = 1'b0;
      voxels_due.push_back(w);
    end else begin
      walk_ray(r);
    end
    rays_sent++;
    @(negedge clk);
  endtask

  function automatic ray_t random_ray();
    ray_t r;
    int mode;
    r.typed = 1'b0;
    r.vx = '0; r.vy = '0; r.vz = '0;
    r.clr = 1'($urandom_range(0, 1));
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
      r.hx = $urandom; r.hy = $urandom; r.hz = $urandom;
    end else begin
      r.ox = $signed($urandom_range(0, 1048576)) - 524288;
      r.oy = $signed($urandom_range(0, 1048576)) - 524288;
      r.oz = $signed($urandom_range(0, 1048576)) - 524288;
      r.hx = r.ox + ($urandom_range(0, 4) == 0 ? 0 : $signed($urandom_range(0, 393216)) - 196608);
      r.hy = r.oy + ($urandom_range(0, 4) == 0 ? 0 : $signed($urandom_range(0, 393216)) - 196608);
      r.hz = r.oz + ($urandom_range(0, 4) == 0 ? 0 : $signed($urandom_range(0, 393216)) - 196608);
      if (mode == 1) begin
        r.hx = r.ox; r.hy = r.oy; r.hz = r.oz;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Receiver: alternates free-running and random stalls, with one long hold-off.
  int rx_phase = 0;
  int hold_left = 0;
  logic held = 1'b0;
  always @(negedge clk) begin
    rx_phase = (rx_phase + 1) % 120;
    if (!held && rays_sent >= 70) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else if (rx_phase < 40) begin
      out_ready = 1'b1;
    end else begin
      out_ready = ($urandom_range(0, 9) < 6);
    end
  end

  always @(posedge clk) begin
    voxel_word_t w;
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (voxels_due.size() == 0) begin
        $error("unexpected voxel word %0h %0h %0h", out_voxel_x, out_voxel_y, out_voxel_z);
        errors++;
      end else begin
        w = voxels_due.pop_front();
        check_field("voxel_x", w.x, out_voxel_x);
        check_field("voxel_y", w.y, out_voxel_y);
        check_field("voxel_z", w.z, out_voxel_z);
        check_field("last", 24'(w.last), 24'(out_last));
        check_field("truncated", 24'(w.trunc), 24'(out_truncated));
      end
    end
  end

  ray_t directed[$];
  initial begin
    ray_t r;
    // origin x, y, z, hit x, y, z, clearing, typed, expected voxel
    directed = '{
      '{0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 0, 0, 0},
      '{65536, 131072, -65536, 65536, 131072, -65536, 1'b0, 1'b1, 20, 40, -20},
      '{65536, 131072, -65536, 65536, 131072, -65536, 1'b1, 1'b1, 20, 40, -20},
      '{0, 0, 0, 65536, 0, 0, 1'b0, 1'b0, 0, 0, 0},
      '{0, 0, 0, -65536, 0, 0, 1'b1, 1'b0, 0, 0, 0},
      '{0, 0, 0, 0, 98304, 0, 1'b1, 1'b0, 0, 0, 0},
      '{0, 0, 0, 0, 0, -98304, 1'b0, 1'b0, 0, 0, 0},
      '{0, 0, 0, 65536, 65536, 65536, 1'b1, 1'b0, 0, 0, 0},
      '{0, 0, 0, -65536, -65536, -65536, 1'b1, 1'b0, 0, 0, 0},
      '{0, 0, 0, 65536, 65536, 0, 1'b1, 1'b0, 0, 0, 0},
      '{0, 0, 0, 0, 65536, 65536, 1'b1, 1'b0, 0, 0, 0},
      '{0, 0, 0, 655360, 327680, -196608, 1'b1, 1'b0, 0, 0, 0},
      '{0, 0, 0, 3000, 0, 0, 1'b1, 1'b0, 0, 0, 0},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
        32'sh7FFFFFFF, 1'b0, 1'b0, 0, 0, 0},
      '{-32'sh80000000, -32'sh80000000, -32'sh80000000, -32'sh80000000, -32'sh80000000,
        -32'sh80000000, 1'b1, 1'b0, 0, 0, 0},
      '{-32'sh80000000, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -32'sh80000000, 0, 1'b1, 1'b0,
        0, 0, 0},
      '{32'sh7FFFFFFF, -32'sh80000000, 0, -32'sh80000000, 32'sh7FFFFFFF, 0, 1'b0, 1'b0,
        0, 0, 0},
      '{32'sh7FFF0000, 0, 0, 32'sh7FFFFFFF, 0, 0, 1'b0, 1'b0, 0, 0, 0},
      '{-32'sh1, -32'sh1, -32'sh1, 1, 1, 1, 1'b0, 1'b0, 0, 0, 0},
      '{100000, -70000, 5000, -900000, 400000, 120000, 1'b0, 1'b0, 0, 0, 0}
    };
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (directed[i]) send_ray(directed[i]);
    wait_drained();

    for (int setting = 0; setting < 4; setting++) begin
      case (setting)
        0: begin
          write_reg(vrt_pkg::CFG_VOXEL_SCALE, 24'd1);
          write_reg(vrt_pkg::CFG_TRUNC_DIST, 24'd0);
          write_reg(vrt_pkg::CFG_MAX_RAY_LEN, 24'd0);
          write_reg(vrt_pkg::CFG_CARVING_ON, 24'd1);
          write_reg(vrt_pkg::CFG_FROM_ORIGIN, 24'd0);
          write_reg(CFG_SPARE, 24'hFFFFFF);
        end
        1: begin
          write_reg(vrt_pkg::CFG_VOXEL_SCALE, 24'hFFFFFF);
          write_reg(vrt_pkg::CFG_TRUNC_DIST, 24'hFFFFFF);
          write_reg(vrt_pkg::CFG_MAX_RAY_LEN, 24'hFFFFFF);
          write_reg(vrt_pkg::CFG_CARVING_ON, 24'd0);
          write_reg(vrt_pkg::CFG_FROM_ORIGIN, 24'd1);
        end
        2: begin
          write_reg(vrt_pkg::CFG_VOXEL_SCALE, 24'h040000);
          write_reg(vrt_pkg::CFG_TRUNC_DIST, 24'h008000);
          write_reg(vrt_pkg::CFG_MAX_RAY_LEN, 24'h030000);
          write_reg(vrt_pkg::CFG_CARVING_ON, 24'd1);
          write_reg(vrt_pkg::CFG_FROM_ORIGIN, 24'd1);
        end
        default: begin
          write_reg(vrt_pkg::CFG_VOXEL_SCALE, 24'($urandom_range(1, 24'h200000)));
          write_reg(vrt_pkg::CFG_TRUNC_DIST, 24'($urandom_range(0, 24'h020000)));
          write_reg(vrt_pkg::CFG_MAX_RAY_LEN, 24'($urandom_range(0, 24'h080000)));
          write_reg(vrt_pkg::CFG_CARVING_ON, 24'd0);
          write_reg(vrt_pkg::CFG_FROM_ORIGIN, 24'd0);
        end
      endcase
      for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
        r = random_ray();
        send_ray(r);
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && voxels_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (voxels_due.size() != 0) $error("%0d voxel words never arrived", voxels_due.size());
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
